### design/dss_pkg.sv
// Package for the disk seek scheduler: payload structs, codes, sizes and the
// control structs passed to the shared compare unit. No dependencies.
package dss_pkg;

  localparam int MAX_REQ = 64;
  localparam int IDX_W   = $clog2(MAX_REQ);
  localparam int CNT_W   = IDX_W + 1;
  localparam int TRK_W   = 16;
  localparam int SUM_W   = 22;

  typedef enum logic [1:0] {
    MODE_FCFS  = 2'd0,
    MODE_SSTF  = 2'd1,
    MODE_SCAN  = 2'd2,
    MODE_CSCAN = 2'd3
  } mode_t;

  localparam logic [1:0] ERR_NONE  = 2'd0;
  localparam logic [1:0] ERR_RANGE = 2'd1;
  localparam logic [1:0] ERR_FULL  = 2'd2;

  localparam logic [1:0] CFG_MODE  = 2'd0;
  localparam logic [1:0] CFG_START = 2'd1;
  localparam logic [1:0] CFG_MAX   = 2'd2;

  typedef struct packed {
    logic [TRK_W-1:0] request_track;
    logic             batch_end;
  } dss_in_t;

  typedef struct packed {
    logic [TRK_W-1:0] served_track;
    logic [TRK_W-1:0] seek_distance;
    logic [SUM_W-1:0] total_distance;
    logic [1:0]       error_code;
    logic             last_result;
  } dss_out_t;

  typedef struct packed {
    mode_t            mode;
    logic [TRK_W-1:0] start;
    logic [TRK_W-1:0] head;
    logic [TRK_W-1:0] track;
    logic             best_v;
    logic             best_cls;
    logic [TRK_W-1:0] best_key;
  } dss_cmp_in_t;

  typedef struct packed {
    logic             better;
    logic             cls;
    logic [TRK_W-1:0] key;
    logic [TRK_W-1:0] gap;
  } dss_cmp_out_t;

endpackage

### design/dss_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
// No dependencies.
module dss_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data <= mem_r[rd_addr];
  end

endmodule

### design/dss_cmp_unit.sv
// Shared distance and ordering unit: one absolute difference and one
// candidate-against-best comparison. Depends on dss_pkg.
module dss_cmp_unit (
  input  dss_pkg::dss_cmp_in_t  cmp_in,
  output dss_pkg::dss_cmp_out_t cmp_out
);

  logic [dss_pkg::TRK_W-1:0] gap;
  logic                      cls;
  logic                      same_better;

  always_comb begin
    gap = (cmp_in.track > cmp_in.head) ? cmp_in.track - cmp_in.head
                                       : cmp_in.head - cmp_in.track;
    cls = (cmp_in.track < cmp_in.start);
    if (cls && (cmp_in.mode == dss_pkg::MODE_SCAN)) begin
      same_better = cmp_in.track > cmp_in.best_key;
    end else begin
      same_better = cmp_in.track < cmp_in.best_key;
    end
    cmp_out.gap = gap;
    cmp_out.cls = cls;
    case (cmp_in.mode)
      dss_pkg::MODE_FCFS: begin
        cmp_out.better = !cmp_in.best_v;
        cmp_out.key    = cmp_in.track;
      end
      dss_pkg::MODE_SSTF: begin
        cmp_out.better = !cmp_in.best_v || (gap < cmp_in.best_key);
        cmp_out.key    = gap;
      end
      default: begin
        cmp_out.better = !cmp_in.best_v || (cls < cmp_in.best_cls) ||
                         ((cls == cmp_in.best_cls) && same_better);
        cmp_out.key    = cmp_in.track;
      end
    endcase
  end

endmodule

### design/disk_seek_scheduler.sv
// Top level of the disk seek scheduler: request store, sequencer and output
// register. Depends on dss_pkg, dss_ram and dss_cmp_unit.
//
//   Port group | Direction | Carries
//   in_*       | input     | one request transaction (track, batch end flag)
//   out_*      | output    | one result transaction (track, distances, error, last)
//   cfg_*      | input     | register writes (mode, start track, max track)
//
// After the closing request, each of the n results comes from one search: one
// compare unit walks the request RAM one entry per cycle, a last step adds
// the final compare, then it is emitted. Synchronous active-low reset clears control
// state and the served marks. Input is held off while a sequence runs or a
// result waits; a stalled output halts the sequencer in its emit step.
module disk_seek_scheduler (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  dss_pkg::dss_in_t in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output dss_pkg::dss_out_t out_data,
  input  logic             cfg_wr_en,
  input  logic [1:0]       cfg_index,
  input  logic [15:0]      cfg_wdata
);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_SEARCH = 4'b0010,
    S_LAST   = 4'b0100,
    S_EMIT   = 4'b1000
  } state_t;

  state_t                      state_r, state_nxt;
  dss_pkg::mode_t              mode_r;
  logic [dss_pkg::TRK_W-1:0]   start_r, max_r;
  logic [dss_pkg::CNT_W-1:0]   count_r, count_nxt;
  logic [dss_pkg::CNT_W-1:0]   n_r, n_nxt;
  logic [dss_pkg::CNT_W-1:0]   k_r, k_nxt;
  logic [dss_pkg::MAX_REQ-1:0] marks_r, marks_nxt;
  logic [dss_pkg::IDX_W-1:0]   scan_r, scan_nxt;
  logic [dss_pkg::IDX_W-1:0]   cmp_idx_r;
  logic                        cmp_v_r, cmp_v_nxt;
  logic                        best_v_r, best_v_nxt;
  logic                        best_cls_r, best_cls_nxt;
  logic [dss_pkg::TRK_W-1:0]   best_key_r, best_key_nxt;
  logic [dss_pkg::TRK_W-1:0]   best_trk_r, best_trk_nxt;
  logic [dss_pkg::IDX_W-1:0]   best_idx_r, best_idx_nxt;
  logic [dss_pkg::TRK_W-1:0]   head_r, head_nxt;
  logic [dss_pkg::SUM_W-1:0]   sum_r, sum_nxt;
  logic [1:0]                  err_r, err_nxt;
  logic                        out_valid_r, out_valid_nxt;
  dss_pkg::dss_out_t           out_data_r, out_data_nxt;

  logic                        in_fire, emit_fire, store;
  logic [1:0]                  in_err;
  logic [dss_pkg::CNT_W-1:0]   new_count;
  logic [dss_pkg::TRK_W-1:0]   ram_rdata;
  dss_pkg::dss_cmp_in_t        cmp_in;
  dss_pkg::dss_cmp_out_t       cmp_out;

  assign in_ready  = (state_r == S_IDLE) && !out_valid_r;
  assign in_fire   = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign emit_fire = (state_r == S_EMIT) && (!out_valid_r || out_ready);

  always_comb begin
    if (in_data.request_track > max_r) begin
      in_err = dss_pkg::ERR_RANGE;
    end else if (count_r == dss_pkg::CNT_W'(dss_pkg::MAX_REQ)) begin
      in_err = dss_pkg::ERR_FULL;
    end else begin
      in_err = dss_pkg::ERR_NONE;
    end
    store     = in_fire && (in_err == dss_pkg::ERR_NONE);
    new_count = count_r + dss_pkg::CNT_W'(store);
  end

  dss_ram #(
    .WIDTH(dss_pkg::TRK_W),
    .DEPTH(dss_pkg::MAX_REQ)
  ) u_store (
    .clk    (clk),
    .wr_en  (store),
    .wr_addr(count_r[dss_pkg::IDX_W-1:0]),
    .wr_data(in_data.request_track),
    .rd_addr(scan_r),
    .rd_data(ram_rdata)
  );

  always_comb begin
    cmp_in.mode     = mode_r;
    cmp_in.start    = start_r;
    cmp_in.head     = head_r;
    cmp_in.track    = (state_r == S_EMIT) ? best_trk_r : ram_rdata;
    cmp_in.best_v   = best_v_r;
    cmp_in.best_cls = best_cls_r;
    cmp_in.best_key = best_key_r;
  end

  dss_cmp_unit u_cmp (
    .cmp_in (cmp_in),
    .cmp_out(cmp_out)
  );

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = new_count;
    n_nxt         = n_r;
    k_nxt         = k_r;
    marks_nxt     = marks_r;
    scan_nxt      = scan_r;
    cmp_v_nxt     = 1'b0;
    best_v_nxt    = best_v_r;
    best_cls_nxt  = best_cls_r;
    best_key_nxt  = best_key_r;
    best_trk_nxt  = best_trk_r;
    best_idx_nxt  = best_idx_r;
    head_nxt      = head_r;
    sum_nxt       = sum_r;
    err_nxt       = err_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;

    if (cmp_v_r && !marks_r[cmp_idx_r] && cmp_out.better) begin
      best_v_nxt   = 1'b1;
      best_cls_nxt = cmp_out.cls;
      best_key_nxt = cmp_out.key;
      best_trk_nxt = ram_rdata;
      best_idx_nxt = cmp_idx_r;
    end

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          out_data_nxt.served_track   = in_data.request_track;
          out_data_nxt.seek_distance  = '0;
          out_data_nxt.total_distance = '0;
          out_data_nxt.error_code     = in_err;
          out_data_nxt.last_result    = in_data.batch_end;
          if (!in_data.batch_end) begin
            out_valid_nxt = (in_err != dss_pkg::ERR_NONE);
          end else if (new_count == '0) begin
            out_valid_nxt = 1'b1;
          end else begin
            err_nxt    = in_err;
            n_nxt      = new_count;
            k_nxt      = '0;
            head_nxt   = start_r;
            sum_nxt    = '0;
            scan_nxt   = '0;
            best_v_nxt = 1'b0;
            state_nxt  = S_SEARCH;
          end
        end
      end
      S_SEARCH: begin
        cmp_v_nxt = 1'b1;
        if ({1'b0, scan_r} == n_r - dss_pkg::CNT_W'(1)) begin
          state_nxt = S_LAST;
        end else begin
          scan_nxt = scan_r + dss_pkg::IDX_W'(1);
        end
      end
      S_LAST: begin
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (emit_fire) begin
          out_valid_nxt               = 1'b1;
          out_data_nxt.served_track   = best_trk_r;
          out_data_nxt.seek_distance  = cmp_out.gap;
          out_data_nxt.total_distance = sum_r + dss_pkg::SUM_W'(cmp_out.gap);
          out_data_nxt.error_code     = err_r;
          out_data_nxt.last_result    = (k_r + dss_pkg::CNT_W'(1) == n_r);
          sum_nxt                     = sum_r + dss_pkg::SUM_W'(cmp_out.gap);
          head_nxt                    = best_trk_r;
          marks_nxt[best_idx_r]       = 1'b1;
          k_nxt                       = k_r + dss_pkg::CNT_W'(1);
          scan_nxt                    = '0;
          best_v_nxt                  = 1'b0;
          if (k_r + dss_pkg::CNT_W'(1) == n_r) begin
            marks_nxt = '0;
            count_nxt = '0;
            state_nxt = S_IDLE;
          end else begin
            state_nxt = S_SEARCH;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      mode_r      <= dss_pkg::MODE_FCFS;
      start_r     <= '0;
      max_r       <= '1;
      count_r     <= '0;
      marks_r     <= '0;
      cmp_v_r     <= 1'b0;
      best_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      marks_r     <= marks_nxt;
      cmp_v_r     <= cmp_v_nxt;
      best_v_r    <= best_v_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        case (cfg_index)
          dss_pkg::CFG_MODE:  mode_r  <= dss_pkg::mode_t'(cfg_wdata[1:0]);
          dss_pkg::CFG_START: start_r <= cfg_wdata;
          dss_pkg::CFG_MAX:   max_r   <= cfg_wdata;
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    n_r        <= n_nxt;
    k_r        <= k_nxt;
    scan_r     <= scan_nxt;
    cmp_idx_r  <= scan_r;
    best_cls_r <= best_cls_nxt;
    best_key_r <= best_key_nxt;
    best_trk_r <= best_trk_nxt;
    best_idx_r <= best_idx_nxt;
    head_r     <= head_nxt;
    sum_r      <= sum_nxt;
    err_r      <= err_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

### dv/tb_top.sv
// Self-checking testbench for disk_seek_scheduler: directed, capacity and random
// request batches with a built-in schedule predictor. Depends on dss_pkg and the
// disk_seek_scheduler RTL only.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 5000000;
  localparam int SETTLE      = 4;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_ready;
  dss_pkg::dss_in_t  in_data;
  logic              out_valid;
  logic              out_ready;
  dss_pkg::dss_out_t out_data;
  logic              cfg_wr_en;
  logic [1:0]        cfg_index;
  logic [15:0]       cfg_wdata;

  int          fail_count = 0;
  int          cycle_count = 0;
  int          send_idle_pct;
  int          recv_idle_pct;

  dss_pkg::mode_t            cur_mode;
  logic [dss_pkg::TRK_W-1:0] cur_start;
  logic [dss_pkg::TRK_W-1:0] cur_max;
  logic [dss_pkg::TRK_W-1:0] request_mem [dss_pkg::MAX_REQ];
  bit [dss_pkg::MAX_REQ-1:0] served_mark;
  int                        pending_count;
  logic [dss_pkg::TRK_W-1:0] head_pos;
  dss_pkg::dss_out_t         due_results [$];
  dss_pkg::dss_out_t         want;

  disk_seek_scheduler dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("** disk_seek_scheduler: FAILED **");
    $finish;
  end

  function automatic int pick_next();
    int                        best;
    logic                      best_cls;
    logic [dss_pkg::TRK_W-1:0] best_key;
    logic [dss_pkg::TRK_W-1:0] trk;
    logic [dss_pkg::TRK_W-1:0] gap;
    logic                      cls;
    bit                        better;
    best     = -1;
    best_cls = 1'b0;
    best_key = '0;
    for (int i = 0; i < pending_count; i++) begin
      if (served_mark[i]) continue;
      trk = request_mem[i];
      case (cur_mode)
        dss_pkg::MODE_FCFS: begin
          return i;
        end
        dss_pkg::MODE_SSTF: begin
          gap = (trk > head_pos) ? trk - head_pos : head_pos - trk;
          if (best < 0 || gap < best_key) begin
            best     = i;
            best_key = gap;
          end
        end
        default: begin
          cls = (trk < cur_start);
          if (best < 0 || cls < best_cls) better = 1'b1;
          else if (cls > best_cls) better = 1'b0;
          else if (cls && cur_mode == dss_pkg::MODE_SCAN) better = (trk > best_key);
          else better = (trk < best_key);
          if (better) begin
            best     = i;
            best_cls = cls;
            best_key = trk;
          end
        end
      endcase
    end
    return best;
  endfunction

  function automatic void predict_request(dss_pkg::dss_in_t item);
    logic [1:0]                err;
    dss_pkg::dss_out_t         r;
    int                        n;
    int                        idx;
    logic [dss_pkg::TRK_W-1:0] trk;
    logic [dss_pkg::TRK_W-1:0] gap;
    logic [22:0]               dist_sum;
    err = dss_pkg::ERR_NONE;
    if (item.request_track > cur_max) begin
      err = dss_pkg::ERR_RANGE;
    end else if (pending_count >= dss_pkg::MAX_REQ) begin
      err = dss_pkg::ERR_FULL;
    end else begin
      request_mem[pending_count] = item.request_track;
      served_mark[pending_count] = 1'b0;
      pending_count++;
    end
    if (!item.batch_end || pending_count == 0) begin
      if (err != dss_pkg::ERR_NONE) begin
        r.served_track   = item.request_track;
        r.seek_distance  = '0;
        r.total_distance = '0;
        r.error_code     = err;
        r.last_result    = item.batch_end;
        due_results.push_back(r);
      end
      return;
    end
    head_pos = cur_start;
    dist_sum = '0;
    n = pending_count;
    for (int k = 0; k < n; k++) begin
      idx = pick_next();
      served_mark[idx] = 1'b1;
      trk  = request_mem[idx];
      gap  = (trk > head_pos) ? trk - head_pos : head_pos - trk;
      head_pos = trk;
      dist_sum = dist_sum + 23'(gap);
      r.served_track   = trk;
      r.seek_distance  = gap;
      r.total_distance = dist_sum[dss_pkg::SUM_W-1:0];
      r.error_code     = err;
      r.last_result    = (k == n - 1);
      due_results.push_back(r);
    end
    pending_count = 0;
    served_mark   = '0;
  endfunction

  function automatic void check_field(string name, int unsigned exp_v, int unsigned got_v);
    if (exp_v != got_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, got_v);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (due_results.size() == 0) begin
        $error("unexpected result transaction: served_track %0d", out_data.served_track);
        fail_count++;
      end else begin
        want = due_results.pop_front();
        check_field("served_track", 32'(want.served_track), 32'(out_data.served_track));
        check_field("seek_distance", 32'(want.seek_distance), 32'(out_data.seek_distance));
        check_field("total_distance", 32'(want.total_distance),
                    32'(out_data.total_distance));
        check_field("error_code", 32'(want.error_code), 32'(out_data.error_code));
        check_field("last_result", 32'(want.last_result), 32'(out_data.last_result));
      end
    end
  end

  task automatic send_request(input logic [dss_pkg::TRK_W-1:0] trk, input logic fin);
    dss_pkg::dss_in_t item;
    item.request_track = trk;
    item.batch_end     = fin;
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_request(item);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic configure(input dss_pkg::mode_t mode, input logic [15:0] start,
                           input logic [15:0] limit);
    cfg_wr_en <= 1'b1;
    cfg_index <= dss_pkg::CFG_MODE;
    cfg_wdata <= {14'd0, mode};
    @(posedge clk);
    cfg_index <= dss_pkg::CFG_START;
    cfg_wdata <= start;
    @(posedge clk);
    cfg_index <= dss_pkg::CFG_MAX;
    cfg_wdata <= limit;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    cur_mode  = mode;
    cur_start = start;
    cur_max   = limit;
  endtask

  function automatic logic [dss_pkg::TRK_W-1:0] pick_track();
    case ($urandom_range(9))
      0: return cur_start;
      1: return (cur_max == 16'hFFFF) ? 16'hFFFF
                : 16'($urandom_range(65535, int'(cur_max) + 1));
      2: return cur_start + 16'($urandom_range(8)) - 16'd4;
      default: return 16'($urandom_range(int'(cur_max), 0));
    endcase
  endfunction

  task automatic new_settings();
    logic [15:0] start;
    logic [15:0] limit;
    case ($urandom_range(5))
      0: start = 16'd0;
      1: start = 16'hFFFF;
      default: start = 16'($urandom_range(65535));
    endcase
    case ($urandom_range(19))
      0: limit = 16'd0;
      1, 2, 3, 4: limit = 16'($urandom_range(65535, 16384));
      default: limit = 16'hFFFF;
    endcase
    configure(dss_pkg::mode_t'($urandom_range(3)), start, limit);
  endtask

  task automatic test_reset_config();
    send_request(16'd700, 1'b0);
    send_request(16'd300, 1'b1);
  endtask

  task automatic test_modes();
    logic [15:0] tracks [5] = '{16'hFFFF, 16'd1100, 16'd0, 16'd900, 16'd1000};
    for (int m = 0; m < 4; m++) begin
      wait_drained();
      configure(dss_pkg::mode_t'(m), 16'd1000, 16'hFFFF);
      foreach (tracks[i]) send_request(tracks[i], i == 4);
    end
  endtask

  task automatic test_errors();
    wait_drained();
    configure(dss_pkg::MODE_SSTF, 16'hFFFF, 16'd40000);
    send_request(16'd40001, 1'b0);
    send_request(16'd40000, 1'b0);
    send_request(16'd0, 1'b0);
    send_request(16'hFFFF, 1'b1);
    send_request(16'd50000, 1'b1);
    wait_drained();
    configure(dss_pkg::MODE_SCAN, 16'd0, 16'd0);
    send_request(16'd1, 1'b0);
    send_request(16'd0, 1'b1);
  endtask

  task automatic test_capacity();
    wait_drained();
    configure(dss_pkg::MODE_CSCAN, 16'($urandom_range(65535)), 16'hFFFF);
    for (int i = 0; i < dss_pkg::MAX_REQ; i++) begin
      send_request(16'($urandom_range(65535)), 1'b0);
    end
    send_request(16'($urandom_range(65535)), 1'b0);
    send_request(16'($urandom_range(65535)), 1'b1);
  endtask

  task automatic test_random(input int n_items);
    int sent;
    int size;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(3) == 0) begin
        wait_drained();
        new_settings();
      end
      size = ($urandom_range(19) == 0) ? $urandom_range(64, 20) : $urandom_range(8, 1);
      for (int j = 0; j < size; j++) send_request(pick_track(), j == size - 1);
      sent += size;
    end
  endtask

  initial begin
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    out_ready <= 1'b0;
    cfg_wr_en <= 1'b0;
    cfg_index <= '0;
    cfg_wdata <= '0;
    cur_mode      = dss_pkg::MODE_FCFS;
    cur_start     = '0;
    cur_max       = 16'hFFFF;
    pending_count = 0;
    served_mark   = '0;
    head_pos      = '0;
    send_idle_pct = 24;
    recv_idle_pct = 74;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_config();
    test_modes();
    test_errors();
    test_capacity();
    test_random(45);
    wait_drained();
    send_idle_pct = 74;
    recv_idle_pct = 24;
    test_random(45);
    wait_drained();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random(45);
    wait_drained();
    repeat (200) @(posedge clk);
    if (fail_count == 0) begin
      $display("** disk_seek_scheduler: PASSED **");
    end else begin
      $display("** disk_seek_scheduler: FAILED **");
    end
    $finish;
  end

endmodule
